// ----- hdl/stvt_pkg.sv -----
// Shared constants and types for the segment tube voxel test pipeline.
package stvt_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int VOXEL_BITS_DEF = 12;
    localparam int RAD_W          = 20;
    localparam int VAL_W          = 8;
    localparam int MUL_CHUNK      = 32;
    localparam int MUL_LAT        = 3;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [APB_AW-1:0] ADDR_INTERP = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_RMAX   = 3'd4;

    localparam logic [RAD_W-1:0] RMAX_RESET = 20'd256;

    typedef struct packed {
        logic degen;
        logic proj_ok;
        logic at_a;
    } seg_flags_t;

endpackage

// ----- hdl/stvt_mul.sv -----
// Unsigned multiplier built from partial products of 32-bit chunks over three register stages.
module stvt_mul
    import stvt_pkg::*;
#(
    parameter int WA = 32,
    parameter int WB = 32
)
(
    input  logic             clk,
    input  logic             ce,
    input  logic [WA-1:0]    a,
    input  logic [WB-1:0]    b,
    output logic [WA+WB-1:0] p
);

    localparam int NA = (WA + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int NB = (WB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int PW = WA + WB;

    logic [NA*MUL_CHUNK-1:0] a_pad;
    logic [NB*MUL_CHUNK-1:0] b_pad;
    logic [2*MUL_CHUNK-1:0]  pp_next [NA][NB];
    logic [2*MUL_CHUNK-1:0]  pp_reg  [NA][NB];
    logic [PW-1:0]           row_next [NA];
    logic [PW-1:0]           row_reg  [NA];
    logic [PW-1:0]           sum_next;
    logic [PW-1:0]           sum_reg;

    assign a_pad = (NA*MUL_CHUNK)'(a);
    assign b_pad = (NB*MUL_CHUNK)'(b);

    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                pp_next[i][j] = a_pad[i*MUL_CHUNK +: MUL_CHUNK] * b_pad[j*MUL_CHUNK +: MUL_CHUNK];
            end
        end
    end

    // Each row is one chunk of a against all of b; the sums stay exact modulo 2^PW.
    always_comb
    begin
        for (int i = 0; i < NA; i++)
        begin
            row_next[i] = '0;
            for (int j = 0; j < NB; j++)
            begin
                row_next[i] = row_next[i] + (PW'(pp_reg[i][j]) << (j*MUL_CHUNK));
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < NA; i++)
        begin
            sum_next = sum_next + (row_reg[i] << (i*MUL_CHUNK));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            pp_reg  <= pp_next;
            row_reg <= row_next;
            sum_reg <= sum_next;
        end
    end

    assign p = sum_reg;

endmodule

// ----- hdl/stvt_dly.sv -----
// Fixed-length shift line that keeps side data aligned with the multipliers.
module stvt_dly
    import stvt_pkg::*;
#(
    parameter int W = 8,
    parameter int N = MUL_LAT
)
(
    input  logic         clk,
    input  logic         ce,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[N-1];

endmodule

// ----- hdl/stvt_scale.sv -----
// Pipelined restoring quotient: largest k below 2^VAL_W with k*den <= lim, one bit per stage.
module stvt_scale
    import stvt_pkg::*;
#(
    parameter int LIMW = 70,
    parameter int DENW = 62
)
(
    input  logic             clk,
    input  logic             ce,
    input  logic [LIMW-1:0]  lim,
    input  logic [DENW-1:0]  den,
    input  logic             ins,
    output logic [VAL_W-1:0] k,
    output logic             ins_out
);

    localparam int SW = ((LIMW > DENW + VAL_W) ? LIMW : DENW + VAL_W) + 1;

    logic [LIMW-1:0]  lim_i  [VAL_W];
    logic [DENW-1:0]  den_i  [VAL_W];
    logic [SW-1:0]    acc_i  [VAL_W];
    logic [VAL_W-1:0] k_i    [VAL_W];
    logic             ins_i  [VAL_W];
    logic [LIMW-1:0]  lim_reg [VAL_W];
    logic [DENW-1:0]  den_reg [VAL_W];
    logic [SW-1:0]    acc_reg [VAL_W];
    logic [VAL_W-1:0] k_reg   [VAL_W];
    logic             ins_reg [VAL_W];

    for (genvar s = 0; s < VAL_W; s++)
    begin : g_step
        localparam int BIT = VAL_W - 1 - s;
        logic [SW-1:0] trial;

        if (s == 0)
        begin : g_first
            assign lim_i[s] = lim;
            assign den_i[s] = den;
            assign acc_i[s] = '0;
            assign k_i[s]   = '0;
            assign ins_i[s] = ins;
        end
        else
        begin : g_next
            assign lim_i[s] = lim_reg[s-1];
            assign den_i[s] = den_reg[s-1];
            assign acc_i[s] = acc_reg[s-1];
            assign k_i[s]   = k_reg[s-1];
            assign ins_i[s] = ins_reg[s-1];
        end

        assign trial = acc_i[s] + (SW'(den_i[s]) << BIT);

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                lim_reg[s] <= lim_i[s];
                den_reg[s] <= den_i[s];
                ins_reg[s] <= ins_i[s];
                if (trial <= SW'(lim_i[s]))
                begin
                    acc_reg[s] <= trial;
                    k_reg[s]   <= k_i[s] | (VAL_W'(1) << BIT);
                end
                else
                begin
                    acc_reg[s] <= acc_i[s];
                    k_reg[s]   <= k_i[s];
                end
            end
        end
    end

    assign k       = k_reg[VAL_W-1];
    assign ins_out = ins_reg[VAL_W-1];

endmodule

// ----- hdl/segment_tube_voxel_test.sv -----
// Throughput: one transaction per cycle; the pipeline runs 11 arithmetic stages and
// 8 quotient stages, and a held output stalls every stage at once.
// Reset clears all valid bits, sets interp_mode to 0 and rmax to 256.
// Payload registers are not reset.
module segment_tube_voxel_test
    import stvt_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int VOXEL_BITS = VOXEL_BITS_DEF,
    localparam int CW     = VOXEL_BITS + FRAC_BITS,
    localparam int IN_BITS = 6*CW + 2*RAD_W + 3*VOXEL_BITS,
    localparam int IN_W   = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W  = ((1 + VAL_W + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, radius_a, radius_b, voxel_x, voxel_y, voxel_z
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // inside_res, voxel_value
    output logic [OUT_W-1:0]  m_axis_tdata,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int DW   = CW + 1;
    localparam int PRW  = 2*DW;
    localparam int LW   = 2*CW + 2;
    localparam int PJW  = 2*CW + 3;
    localparam int MW   = 2*CW + 1;
    localparam int C2W  = 4*CW + 4;
    localparam int NW   = RAD_W + LW;
    localparam int DENW = LW + RAD_W;
    localparam int LIMW = NW + VAL_W;
    localparam int VLEN = 5 + 2*MUL_LAT + VAL_W;
    localparam int SIDE1_W = 3 + LW + RAD_W;
    localparam int SIDE2_W = 3 + NW;

    // Configuration registers.
    logic             interp_reg;
    logic [RAD_W-1:0] rmax_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_reg <= 1'b0;
            rmax_reg   <= RMAX_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr == ADDR_INTERP)
            begin
                interp_reg <= pwdata[0];
            end
            else if (paddr == ADDR_RMAX)
            begin
                rmax_reg <= pwdata[RAD_W-1:0];
            end
        end
    end

    always_comb
    begin
        case (paddr)
            ADDR_INTERP: prdata = APB_DW'(interp_reg);
            ADDR_RMAX:   prdata = APB_DW'(rmax_reg);
            default:     prdata = '0;
        endcase
    end

    // Global stall: every stage moves only when the output register can take a result.
    logic            ce;
    logic [VLEN-1:0] vld_reg;
    logic            out_valid_reg;
    logic            inside_out_reg;
    logic [VAL_W-1:0] value_out_reg;

    assign ce            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (ce)
        begin
            vld_reg       <= {vld_reg[VLEN-2:0], s_axis_tvalid};
            out_valid_reg <= vld_reg[VLEN-1];
        end
    end

    // Stage 1: difference vectors.
    logic signed [CW-1:0] a_c [3];
    logic signed [CW-1:0] b_c [3];
    logic signed [CW-1:0] v_c [3];
    logic [RAD_W-1:0]     ra_in;
    logic [RAD_W-1:0]     rb_in;
    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] ac_reg [3];
    logic [RAD_W-1:0]     ra1_reg, rb1_reg, rmin1_reg;
    logic                 at_a1_reg;
    logic                 at_a_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_c[i] = s_axis_tdata[i*CW +: CW];
            b_c[i] = s_axis_tdata[(3+i)*CW +: CW];
            v_c[i] = CW'($signed(s_axis_tdata[6*CW + 2*RAD_W + i*VOXEL_BITS +: VOXEL_BITS]))
                     <<< FRAC_BITS;
        end
        ra_in = s_axis_tdata[6*CW +: RAD_W];
        rb_in = s_axis_tdata[6*CW + RAD_W +: RAD_W];
        at_a_next = (v_c[0] == a_c[0]) && (v_c[1] == a_c[1]) && (v_c[2] == a_c[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= DW'(b_c[i]) - DW'(a_c[i]);
                ac_reg[i] <= DW'(v_c[i]) - DW'(a_c[i]);
            end
            ra1_reg   <= ra_in;
            rb1_reg   <= rb_in;
            rmin1_reg <= (ra_in < rb_in) ? ra_in : rb_in;
            at_a1_reg <= at_a_next;
        end
    end

    // Stage 2: component products.
    logic signed [PRW-1:0] sq_reg [3];
    logic signed [PRW-1:0] dp_reg [3];
    logic signed [PRW-1:0] xa_reg [3];
    logic signed [PRW-1:0] xb_reg [3];
    logic [RAD_W-1:0]      ra2_reg, rb2_reg, rmin2_reg;
    logic                  at_a2_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= ab_reg[i] * ab_reg[i];
                dp_reg[i] <= ac_reg[i] * ab_reg[i];
            end
            xa_reg[0] <= ac_reg[1] * ab_reg[2];
            xb_reg[0] <= ac_reg[2] * ab_reg[1];
            xa_reg[1] <= ac_reg[2] * ab_reg[0];
            xb_reg[1] <= ac_reg[0] * ab_reg[2];
            xa_reg[2] <= ac_reg[0] * ab_reg[1];
            xb_reg[2] <= ac_reg[1] * ab_reg[0];
            ra2_reg   <= ra1_reg;
            rb2_reg   <= rb1_reg;
            rmin2_reg <= rmin1_reg;
            at_a2_reg <= at_a1_reg;
        end
    end

    // Stage 3: squared length, projection and cross product.
    logic [LW-1:0]          len2_reg;
    logic signed [PJW-1:0]  proj_reg;
    logic signed [PRW-1:0]  cr_reg [3];
    logic [RAD_W-1:0]       ra3_reg, rb3_reg, rmin3_reg;
    logic                   at_a3_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            len2_reg <= LW'(sq_reg[0]) + LW'(sq_reg[1]) + LW'(sq_reg[2]);
            proj_reg <= PJW'(dp_reg[0]) + PJW'(dp_reg[1]) + PJW'(dp_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                cr_reg[i] <= xa_reg[i] - xb_reg[i];
            end
            ra3_reg   <= ra2_reg;
            rb3_reg   <= rb2_reg;
            rmin3_reg <= rmin2_reg;
            at_a3_reg <= at_a2_reg;
        end
    end

    // First multiplier bank: squared cross components, interpolation terms, rmin squared.
    logic [MW-1:0]        cr_mag [3];
    logic [2*MW-1:0]      crsq_p [3];
    logic [LW-1:0]        proj_lo;
    logic [NW-1:0]        pa_p, pb_p;
    logic [2*RAD_W-1:0]   r2_p;
    seg_flags_t           flags3;
    logic [SIDE1_W-1:0]   side1_out;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            cr_mag[i] = cr_reg[i][PRW-1] ? MW'(-cr_reg[i]) : MW'(cr_reg[i]);
        end
        proj_lo        = LW'(proj_reg);
        flags3.degen   = (len2_reg == '0);
        flags3.proj_ok = !proj_reg[PJW-1] && ($signed(PJW'(len2_reg)) >= proj_reg);
        flags3.at_a    = at_a3_reg;
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_crsq
        stvt_mul #(.WA(MW), .WB(MW)) u_mul_crsq
        (
            .clk (clk),
            .ce  (ce),
            .a   (cr_mag[g]),
            .b   (cr_mag[g]),
            .p   (crsq_p[g])
        );
    end

    stvt_mul #(.WA(RAD_W), .WB(LW)) u_mul_pa
    (
        .clk (clk),
        .ce  (ce),
        .a   (ra3_reg),
        .b   (len2_reg - proj_lo),
        .p   (pa_p)
    );

    stvt_mul #(.WA(RAD_W), .WB(LW)) u_mul_pb
    (
        .clk (clk),
        .ce  (ce),
        .a   (rb3_reg),
        .b   (proj_lo),
        .p   (pb_p)
    );

    stvt_mul #(.WA(RAD_W), .WB(RAD_W)) u_mul_r2
    (
        .clk (clk),
        .ce  (ce),
        .a   (rmin3_reg),
        .b   (rmin3_reg),
        .p   (r2_p)
    );

    stvt_dly #(.W(SIDE1_W), .N(MUL_LAT)) u_dly_side1
    (
        .clk  (clk),
        .ce   (ce),
        .din  ({flags3, len2_reg, rmin3_reg}),
        .dout (side1_out)
    );

    // Stage 7: squared cross norm and interpolation numerator.
    logic [C2W-1:0]     cross2_reg;
    logic [NW-1:0]      num_reg;
    logic [2*RAD_W-1:0] r2_reg;
    logic [LW-1:0]      len2_7_reg;
    logic [RAD_W-1:0]   rmin7_reg;
    seg_flags_t         flags7_reg;

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            cross2_reg <= C2W'(crsq_p[0]) + C2W'(crsq_p[1]) + C2W'(crsq_p[2]);
            num_reg    <= pa_p + pb_p;
            r2_reg     <= r2_p;
            flags7_reg <= side1_out[SIDE1_W-1 -: 3];
            len2_7_reg <= side1_out[RAD_W +: LW];
            rmin7_reg  <= side1_out[RAD_W-1:0];
        end
    end

    // Second multiplier bank: both sides of the radius test and the quotient divisor.
    logic [LW-1:0]        x_op;
    logic [NW-1:0]        p_op, q_op, num_s;
    logic [C2W+LW-1:0]    lhs_p;
    logic [2*NW-1:0]      rhs_p;
    logic [DENW-1:0]      den_p;
    logic [SIDE2_W-1:0]   side2_out;

    assign x_op  = interp_reg ? len2_7_reg : LW'(1);
    assign p_op  = interp_reg ? num_reg : NW'(r2_reg);
    assign q_op  = interp_reg ? num_reg : NW'(len2_7_reg);
    assign num_s = interp_reg ? num_reg : NW'(rmin7_reg);

    stvt_mul #(.WA(C2W), .WB(LW)) u_mul_lhs
    (
        .clk (clk),
        .ce  (ce),
        .a   (cross2_reg),
        .b   (x_op),
        .p   (lhs_p)
    );

    stvt_mul #(.WA(NW), .WB(NW)) u_mul_rhs
    (
        .clk (clk),
        .ce  (ce),
        .a   (p_op),
        .b   (q_op),
        .p   (rhs_p)
    );

    stvt_mul #(.WA(LW), .WB(RAD_W)) u_mul_den
    (
        .clk (clk),
        .ce  (ce),
        .a   (x_op),
        .b   (rmax_reg),
        .p   (den_p)
    );

    stvt_dly #(.W(SIDE2_W), .N(MUL_LAT)) u_dly_side2
    (
        .clk  (clk),
        .ce   (ce),
        .din  ({flags7_reg, num_s}),
        .dout (side2_out)
    );

    // Stage 11: inside decision and quotient operands.
    seg_flags_t       flags10;
    logic [NW-1:0]    num10;
    logic             inside11_reg;
    logic [LIMW-1:0]  lim11_reg;
    logic [DENW-1:0]  den11_reg;
    logic             inside_next;

    assign flags10 = side2_out[SIDE2_W-1 -: 3];
    assign num10   = side2_out[NW-1:0];

    always_comb
    begin
        if (flags10.degen)
        begin
            inside_next = !interp_reg && flags10.at_a;
        end
        else
        begin
            inside_next = flags10.proj_ok && (lhs_p <= (C2W+LW)'(rhs_p));
        end
    end

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            inside11_reg <= inside_next;
            lim11_reg    <= (LIMW'(num10) << VAL_W) - LIMW'(num10);
            den11_reg    <= den_p;
        end
    end

    // Quotient stages and output register.
    logic [VAL_W-1:0] k_out;
    logic             ins_out;

    stvt_scale #(.LIMW(LIMW), .DENW(DENW)) u_scale
    (
        .clk     (clk),
        .ce      (ce),
        .lim     (lim11_reg),
        .den     (den11_reg),
        .ins     (inside11_reg),
        .k       (k_out),
        .ins_out (ins_out)
    );

    always_ff @(posedge clk)
    begin
        if (ce)
        begin
            inside_out_reg <= ins_out;
            value_out_reg  <= ins_out ? k_out : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({value_out_reg, inside_out_reg});

    // A held result freezes the whole pipeline, including the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output is stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[VAL_W:1] == '0))
        else $error("nonzero value on a voxel that is outside");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> vld_reg[0])
        else $error("accepted transaction lost at the first stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && (paddr == ADDR_RMAX)) |=> (rmax_reg == $past(pwdata[RAD_W-1:0])))
        else $error("rmax write not taken");

endmodule

// ----- tb/tb_segment_tube_voxel_test.sv -----
// Self-checking testbench for the segment tube voxel test pipeline.
module tb_segment_tube_voxel_test;
    import stvt_pkg::*;

    localparam int CW       = VOXEL_BITS_DEF + FRAC_BITS_DEF;
    localparam int IN_W     = ((6*CW + 2*RAD_W + 3*VOXEL_BITS_DEF + 7) / 8) * 8;
    localparam int OUT_W    = ((1 + VAL_W + 7) / 8) * 8;
    localparam int LATENCY  = 20;
    localparam int WDOG_MAX = 5000;

    typedef struct {
        logic signed [CW-1:0]             ax, ay, az, bx, by, bz;
        logic [RAD_W-1:0]                 ra, rb;
        logic signed [VOXEL_BITS_DEF-1:0] vx, vy, vz;
    } tube_item_t;

    typedef struct {
        logic             hit;
        logic [VAL_W-1:0] value;
    } tube_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, radius_a, radius_b, voxel_x, voxel_y, voxel_z
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // inside_res, voxel_value
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    segment_tube_voxel_test dut (.*);

    // Shadow copy of the configuration registers.
    logic             interp_q = 1'b0;
    logic [RAD_W-1:0] rmax_q = RMAX_RESET;

    tube_result_t expected_q[$];
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    int           n_sent = 0, n_checked = 0, n_inside = 0, n_fail = 0;
    int           idle_cycles = 0;

    initial forever #2 clk = ~clk;

    function automatic logic [255:0] mag_sq(longint v);
        logic [255:0] m;
        m = (v < 0) ? 256'(-v) : 256'(v);
        return m * m;
    endfunction

    // Largest k in [0,255] with k * den <= 255 * num.
    function automatic logic [VAL_W-1:0] scale_255(logic [255:0] num, logic [255:0] den);
        logic [255:0] q;
        if (den == 0)
            return 8'd255;
        q = (num * 255) / den;
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    function automatic tube_result_t predict_tube(tube_item_t it);
        longint       a[3], b[3], c[3], ab[3], ac[3];
        longint       len2, proj, cx, cy, cz;
        logic [255:0] cross2, wl, num;
        logic [RAD_W-1:0] rmin;
        bit           at_a;
        tube_result_t r;
        a = '{longint'(it.ax), longint'(it.ay), longint'(it.az)};
        b = '{longint'(it.bx), longint'(it.by), longint'(it.bz)};
        c = '{longint'(it.vx) * 256, longint'(it.vy) * 256, longint'(it.vz) * 256};
        len2 = 0;
        proj = 0;
        at_a = 1;
        for (int i = 0; i < 3; i++)
        begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            len2 += ab[i] * ab[i];
            proj += ac[i] * ab[i];
            if (ac[i] != 0)
                at_a = 0;
        end
        rmin = (it.ra < it.rb) ? it.ra : it.rb;
        r.hit = 1'b0;
        r.value = '0;
        if (len2 == 0)
        begin
            if (!interp_q && at_a)
            begin
                r.hit = 1'b1;
                r.value = scale_255(256'(rmin), 256'(rmax_q));
            end
        end
        else if (proj >= 0 && proj <= len2)
        begin
            cx = ac[1] * ab[2] - ac[2] * ab[1];
            cy = ac[2] * ab[0] - ac[0] * ab[2];
            cz = ac[0] * ab[1] - ac[1] * ab[0];
            cross2 = mag_sq(cx) + mag_sq(cy) + mag_sq(cz);
            wl = 256'(len2);
            if (interp_q)
            begin
                num = 256'(it.ra) * 256'(len2 - proj) + 256'(it.rb) * 256'(proj);
                if (cross2 * wl <= num * num)
                begin
                    r.hit = 1'b1;
                    r.value = scale_255(num, wl * 256'(rmax_q));
                end
            end
            else if (cross2 <= 256'(rmin) * 256'(rmin) * wl)
            begin
                r.hit = 1'b1;
                r.value = scale_255(256'(rmin), 256'(rmax_q));
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        n_fail++;
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_INTERP)
            interp_q = data[0];
        else
            rmax_q = data[RAD_W-1:0];
    endtask

    // Registers change only once every result is out and the pipeline is empty.
    task automatic settle_and_configure(logic mode, logic [RAD_W-1:0] rmax);
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        apb_write(ADDR_INTERP, APB_DW'(mode));
        apb_write(ADDR_RMAX, APB_DW'(rmax));
    endtask

    task automatic send_voxel(tube_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_W'({it.vz, it.vy, it.vx, it.rb, it.ra,
                               it.bz, it.by, it.bx, it.az, it.ay, it.ax});
        expected_q.push_back(predict_tube(it));
        do @(posedge clk); while (!s_axis_tready);
        n_sent++;
    endtask

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        tube_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_q.size() == 0)
                report_mismatch("result with no transaction outstanding");
            else
            begin
                e = expected_q.pop_front();
                n_checked++;
                if (e.hit)
                    n_inside++;
                if (m_axis_tdata[0] !== e.hit)
                    report_mismatch($sformatf("inside_res %b, want %b",
                                              m_axis_tdata[0], e.hit));
                if (m_axis_tdata[8:1] !== e.value)
                    report_mismatch($sformatf("voxel_value %0d, want %0d",
                                              m_axis_tdata[8:1], e.value));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX)
        begin
            $display("watchdog expired with %0d results outstanding", expected_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic tube_item_t make_item(int vx, int vy, int vz,
                                             int ax, int ay, int az,
                                             int bx, int by, int bz, int ra, int rb);
        tube_item_t it;
        it.vx = VOXEL_BITS_DEF'(vx); it.vy = VOXEL_BITS_DEF'(vy); it.vz = VOXEL_BITS_DEF'(vz);
        it.ax = CW'(ax); it.ay = CW'(ay); it.az = CW'(az);
        it.bx = CW'(bx); it.by = CW'(by); it.bz = CW'(bz);
        it.ra = RAD_W'(ra); it.rb = RAD_W'(rb);
        return it;
    endfunction

    // Mostly voxels close to short segments so that inside and outside both occur.
    function automatic tube_item_t random_item();
        tube_item_t it;
        int v[3], sel, span, rspan;
        sel = $urandom_range(99);
        if (sel < 15)
        begin
            it = make_item($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom, $urandom, $urandom, $urandom, $urandom);
            return it;
        end
        span = ($urandom_range(3) == 0) ? 60000 : 3000;
        rspan = ($urandom_range(3) == 0) ? 1048575 : 2500;
        for (int i = 0; i < 3; i++)
            v[i] = int'($urandom_range(4095)) - 2048;
        if ($urandom_range(3) == 0)
            for (int i = 0; i < 3; i++)
                v[i] = int'($urandom_range(40)) - 20;
        it = make_item(v[0], v[1], v[2],
                       v[0]*256 + int'($urandom_range(2*span)) - span,
                       v[1]*256 + int'($urandom_range(2*span)) - span,
                       v[2]*256 + int'($urandom_range(2*span)) - span,
                       v[0]*256 + int'($urandom_range(2*span)) - span,
                       v[1]*256 + int'($urandom_range(2*span)) - span,
                       v[2]*256 + int'($urandom_range(2*span)) - span,
                       $urandom_range(rspan), $urandom_range(rspan));
        if (sel < 25)
        begin
            it.bx = it.ax; it.by = it.ay; it.bz = it.az;
        end
        else if (sel < 32)
        begin
            it.ax = CW'(v[0]*256); it.ay = CW'(v[1]*256); it.az = CW'(v[2]*256);
        end
        else if (sel < 39)
        begin
            it.bx = CW'(v[0]*256); it.by = CW'(v[1]*256); it.bz = CW'(v[2]*256);
        end
        if (sel >= 25 && sel < 29)
        begin
            it.bx = it.ax; it.by = it.ay; it.bz = it.az;
        end
        return it;
    endfunction

    task automatic directed_cases();
        // Voxel on the axis, at each endpoint, beyond each end, off to the side.
        send_voxel(make_item(5, 0, 0, 0, 0, 0, 2560, 0, 0, 512, 1024));
        send_voxel(make_item(0, 0, 0, 0, 0, 0, 2560, 0, 0, 512, 1024));
        send_voxel(make_item(10, 0, 0, 0, 0, 0, 2560, 0, 0, 512, 1024));
        send_voxel(make_item(-1, 0, 0, 0, 0, 0, 2560, 0, 0, 512, 1024));
        send_voxel(make_item(11, 0, 0, 0, 0, 0, 2560, 0, 0, 512, 1024));
        send_voxel(make_item(5, 2, 0, 0, 0, 0, 2560, 0, 0, 512, 1024));
        send_voxel(make_item(5, 3, 0, 0, 0, 0, 2560, 0, 0, 512, 1024));
        // Degenerate segments, with the voxel on the point and off it.
        send_voxel(make_item(3, -2, 7, 768, -512, 1792, 768, -512, 1792, 300, 200));
        send_voxel(make_item(3, -2, 6, 768, -512, 1792, 768, -512, 1792, 300, 200));
        // Field extremes and radii far above rmax.
        send_voxel(make_item(-2048, -2048, -2048, -524288, -524288, -524288,
                             524287, 524287, 524287, 1048575, 1048575));
        send_voxel(make_item(2047, 2047, 2047, 524287, 524287, 524287,
                             -524288, -524288, -524288, 0, 1048575));
        send_voxel(make_item(2047, -2048, 0, 524287, -524288, 0,
                             524287, -524288, 0, 0, 0));
        send_voxel(make_item(0, 0, 0, -524288, 524287, -524288,
                             524287, -524288, 524287, 1048575, 0));
    endtask

    task automatic test_directed();
        directed_cases();
        settle_and_configure(1'b1, RMAX_RESET);
        directed_cases();
        settle_and_configure(1'b0, '0);
        directed_cases();
        settle_and_configure(1'b1, '0);
        directed_cases();
    endtask

    task automatic test_random(logic mode, logic [RAD_W-1:0] rmax,
                               int idle_pct, int stall_pct, int count);
        settle_and_configure(mode, rmax);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_voxel(random_item());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1'b0, RMAX_RESET, 0, 0, 300);
        test_random(1'b1, RMAX_RESET, 86, 0, 300);
        test_random(1'b0, 20'd1, 0, 86, 300);
        test_random(1'b1, 20'hFFFFF, 7, 7, 300);
        test_random(1'b1, RAD_W'($urandom_range(1, 4000)), 0, 0, 300);
        test_random(1'b0, RAD_W'($urandom_range(1, 1048575)), 7, 7, 300);
        s_axis_tvalid <= 1'b0;
        wait (expected_q.size() == 0);
        repeat (LATENCY + 5) @(posedge clk);
        $display("sent %0d voxel transactions over both radius modes and six rmax settings,",
                 n_sent);
        $display("checked %0d results, %0d of them inside, with %0d mismatches",
                 n_checked, n_inside, n_fail);
        if (n_fail == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
